FILE: hdl/oas_pkg.sv
// Shared types and constants for the ordered array set.
package oas_pkg;

    localparam int KEY_W  = 32;
    localparam int POS_W  = 6;
    localparam int SIZE_W = 7;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_DUP       = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_SHIFT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

    typedef struct packed {
        t_status             status;
        logic [POS_W-1:0]    position;
        logic                present;
        logic [SIZE_W-1:0]   set_size;
    } t_result;

endpackage

FILE: hdl/oas_store.sv
// Key store: one write port and one registered read port.
module oas_store
    import oas_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  t_mem_ctl      i_ctl,
    input  logic [AW-1:0] i_rd_addr,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/oas_seq.sv
// Command sequencer: scans the store with one shared comparator and shifts entries on erase.
module oas_seq
    import oas_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int IW       = 6,
    parameter int CW       = 7,
    parameter int SW       = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [1:0]    i_cmd,
    input  logic [KEY_W-1:0] i_key,
    output logic          o_busy,
    output t_mem_ctl      o_mem_ctl,
    output logic [IW-1:0] o_rd_addr,
    output logic [IW-1:0] o_wr_addr,
    output logic [SW-1:0] o_wr_data,
    input  logic [SW-1:0] i_rd_data,
    output logic          o_res_valid,
    output t_result       o_res,
    input  logic          i_res_take
);

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    t_state        r_state, n_state;
    t_cmd          r_cmd, n_cmd;
    logic [SW-1:0] r_key, n_key;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_pend, n_pend;
    logic [IW-1:0] r_pidx, n_pidx;
    logic          r_hit, n_hit;
    logic [IW-1:0] r_hit_idx, n_hit_idx;
    logic [CW-1:0] r_src, n_src;
    logic [IW-1:0] r_wr, n_wr;
    logic          r_spend, n_spend;
    t_status       r_status, n_status;
    logic [IW-1:0] r_pos, n_pos;

    logic          match;
    logic          scan_end;
    logic          shift_end;
    logic [31:0]   pos_ext;
    logic [31:0]   size_ext;

    assign match     = r_pend && (i_rd_data == r_key);
    assign scan_end  = match || ((r_idx == r_count) && !r_pend);
    assign shift_end = (r_src == r_count) && !r_spend;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (scan_end) n_state = S_APPLY;
            end
            S_APPLY: begin
                if (r_cmd == CMD_ERASE && r_hit) n_state = S_SHIFT;
                else n_state = S_DONE;
            end
            S_SHIFT: begin
                if (shift_end) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_count   = r_count;
        n_idx     = r_idx;
        n_pend    = r_pend;
        n_pidx    = r_pidx;
        n_hit     = r_hit;
        n_hit_idx = r_hit_idx;
        n_src     = r_src;
        n_wr      = r_wr;
        n_spend   = r_spend;
        n_status  = r_status;
        n_pos     = r_pos;
        o_mem_ctl = '{rd_en: 1'b0, wr_en: 1'b0};
        o_rd_addr = r_idx[IW-1:0];
        o_wr_addr = r_wr;
        o_wr_data = i_rd_data;
        o_res_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd     = t_cmd'(i_cmd);
                    n_key     = i_key[SW-1:0];
                    n_idx     = '0;
                    n_pend    = 1'b0;
                    n_hit     = 1'b0;
                    n_hit_idx = '0;
                end
            end
            S_SCAN: begin
                n_pend = 1'b0;
                if (match) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_pidx;
                end else if (r_idx != r_count) begin
                    o_mem_ctl.rd_en = 1'b1;
                    o_rd_addr       = r_idx[IW-1:0];
                    n_idx           = r_idx + CW'(1);
                    n_pend          = 1'b1;
                    n_pidx          = r_idx[IW-1:0];
                end
            end
            S_APPLY: begin
                n_status = STAT_OK;
                n_pos    = '0;
                unique case (r_cmd)
                    CMD_INSERT: begin
                        if (r_hit) begin
                            n_status = STAT_DUP;
                            n_pos    = r_hit_idx;
                        end else if (r_count == CAP_C) begin
                            n_status = STAT_FULL;
                        end else begin
                            o_mem_ctl.wr_en = 1'b1;
                            o_wr_addr       = r_count[IW-1:0];
                            o_wr_data       = r_key;
                            n_pos           = r_count[IW-1:0];
                            n_count         = r_count + CW'(1);
                        end
                    end
                    CMD_ERASE: begin
                        if (r_hit) begin
                            n_pos   = r_hit_idx;
                            n_src   = CW'(r_hit_idx) + CW'(1);
                            n_wr    = r_hit_idx;
                            n_spend = 1'b0;
                        end else begin
                            n_status = STAT_NOT_FOUND;
                        end
                    end
                    CMD_LOOKUP: begin
                        if (r_hit) n_pos = r_hit_idx;
                        else n_status = STAT_NOT_FOUND;
                    end
                    CMD_CLEAR: begin
                        n_count = '0;
                    end
                endcase
            end
            S_SHIFT: begin
                n_spend = 1'b0;
                if (r_spend) begin
                    o_mem_ctl.wr_en = 1'b1;
                    o_wr_addr       = r_wr;
                    o_wr_data       = i_rd_data;
                    n_wr            = r_wr + IW'(1);
                end
                if (r_src != r_count) begin
                    o_mem_ctl.rd_en = 1'b1;
                    o_rd_addr       = r_src[IW-1:0];
                    n_src           = r_src + CW'(1);
                    n_spend         = 1'b1;
                end else if (!r_spend) begin
                    n_count = r_count - CW'(1);
                end
            end
            S_DONE: begin
                o_res_valid = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_spend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_spend <= n_spend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_key     <= n_key;
        r_idx     <= n_idx;
        r_pidx    <= n_pidx;
        r_hit     <= n_hit;
        r_hit_idx <= n_hit_idx;
        r_src     <= n_src;
        r_wr      <= n_wr;
        r_status  <= n_status;
        r_pos     <= n_pos;
    end

    assign pos_ext  = 32'(r_pos);
    assign size_ext = 32'(r_count);
    assign o_busy   = (r_state != S_IDLE);

    assign o_res.status   = r_status;
    assign o_res.position = pos_ext[POS_W-1:0];
    assign o_res.present  = r_hit;
    assign o_res.set_size = size_ext[SIZE_W-1:0];

endmodule

FILE: hdl/ordered_array_set.sv
// Ordered array set: unique keys in insertion order, one command per input beat.
// Each command scans the keys held, and the scan reads one entry a cycle.
// One command is handled at a time; the output register lets the next command start
// while a result beat waits.
// Reset empties the set at once, with no clearing pass.
module ordered_array_set
    import oas_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_cmd,
    input  logic [KEY_W-1:0]   i_key,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic [POS_W-1:0]   o_position,
    output logic               o_present,
    output logic [SIZE_W-1:0]  o_set_size
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;

    t_mem_ctl      mem_ctl;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic [SW-1:0] wr_data;
    logic [SW-1:0] rd_data;
    logic          busy;
    logic          res_valid;
    t_result       res;
    logic          res_take;

    logic          r_out_valid;
    t_result       r_out;

    oas_seq #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .CW       (CW),
        .SW       (SW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_cmd       (i_cmd),
        .i_key       (i_key),
        .o_busy      (busy),
        .o_mem_ctl   (mem_ctl),
        .o_rd_addr   (rd_addr),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .i_rd_data   (rd_data),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    oas_store #(
        .DEPTH (CAPACITY),
        .AW    (IW),
        .DW    (SW)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    assign res_take = res_valid && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_stall    = busy;
    assign o_valid    = r_out_valid;
    assign o_status   = r_out.status;
    assign o_position = r_out.position;
    assign o_present  = r_out.present;
    assign o_set_size = r_out.set_size;

endmodule

FILE: tb/ordered_array_set_tb.sv
// Self-checking testbench for the ordered array set: insert, erase, lookup and clear checks.
module ordered_array_set_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import oas_pkg::*;

    localparam int CAPACITY  = 64;
    localparam int POOL_SIZE = 96;

    class set_scoreboard;
        logic [KEY_W-1:0] held_keys [CAPACITY];
        int               held_count;
        t_result          expected_replies [$];
        int unsigned      mismatches;

        function new();
            held_count = 0;
            mismatches = 0;
        endfunction

        function void note_command(t_cmd cmd, logic [KEY_W-1:0] key);
            t_result reply;
            int      hit;
            int      i;
            hit = -1;
            for (i = 0; i < held_count && hit < 0; i++)
                if (held_keys[i] == key)
                    hit = i;
            reply.status   = STAT_OK;
            reply.position = '0;
            reply.present  = (hit >= 0);
            case (cmd)
                CMD_INSERT: begin
                    if (hit >= 0) begin
                        reply.status   = STAT_DUP;
                        reply.position = POS_W'(hit);
                    end else if (held_count >= CAPACITY) begin
                        reply.status = STAT_FULL;
                    end else begin
                        held_keys[held_count] = key;
                        reply.position = POS_W'(held_count);
                        held_count++;
                    end
                end
                CMD_ERASE: begin
                    if (hit < 0) begin
                        reply.status = STAT_NOT_FOUND;
                    end else begin
                        for (i = hit; i + 1 < held_count; i++)
                            held_keys[i] = held_keys[i + 1];
                        held_count--;
                        reply.position = POS_W'(hit);
                    end
                end
                CMD_LOOKUP: begin
                    if (hit < 0)
                        reply.status = STAT_NOT_FOUND;
                    else
                        reply.position = POS_W'(hit);
                end
                default: begin
                    held_count = 0;
                end
            endcase
            reply.set_size = SIZE_W'(held_count);
            expected_replies.push_back(reply);
        endfunction

        function void check_reply(t_result got);
            t_result want;
            if (expected_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: status=%0d position=%0d present=%0d size=%0d",
                             got.status, got.position, got.present, got.set_size);
                return;
            end
            want = expected_replies.pop_front();
            if (got.status !== want.status || got.position !== want.position ||
                got.present !== want.present || got.set_size !== want.set_size) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at %0t: expected status=%0d position=%0d present=%0d ",
                             $realtime, want.status, want.position, want.present,
                             "size=%0d, got status=%0d position=%0d present=%0d size=%0d",
                             want.set_size, got.status, got.position, got.present,
                             got.set_size);
            end
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction
    endclass

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_cmd   = CMD_INSERT;
    logic [KEY_W-1:0]   i_key   = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [1:0]         o_status;
    logic [POS_W-1:0]   o_position;
    logic               o_present;
    logic [SIZE_W-1:0]  o_set_size;

    set_scoreboard      board;
    logic [KEY_W-1:0]   key_pool [POOL_SIZE];
    int                 burst_left;
    int                 stall_mode = 0;
    int                 mode_left  = 0;
    int                 hold_left  = 0;
    logic               stall_hold = 1'b0;

    ordered_array_set #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_cmd      (i_cmd),
        .i_key      (i_key),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_status   (o_status),
        .o_position (o_position),
        .o_present  (o_present),
        .o_set_size (o_set_size)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    task automatic send_command(t_cmd cmd, logic [KEY_W-1:0] key);
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_key   <= key;
        do @(posedge i_clk); while (o_stall);
        board.note_command(cmd, key);
        burst_left--;
        if (burst_left <= 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, $urandom_range(0, 1) ? 8 : 160)) @(posedge i_clk);
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 80)
                                                    : $urandom_range(1, 8);
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.status   = t_status'(o_status);
            got.position = o_position;
            got.present  = o_present;
            got.set_size = o_set_size;
            board.check_reply(got);
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 300);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 3) != 0);
            default: begin
                if (hold_left == 0) begin
                    hold_left  = $urandom_range(1, 20);
                    stall_hold = ~stall_hold;
                end else begin
                    hold_left--;
                end
                i_stall <= stall_hold;
            end
        endcase
    end

    initial begin
        #10ms;
        $display("FAIL");
        $finish;
    end

    initial begin
        int   pick;
        int   ins_pct;
        int   era_pct;
        t_cmd cmd;
        board = new();
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        burst_left = $urandom_range(1, 8);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_command(CMD_INSERT, 32'h0000_0000);
        send_command(CMD_INSERT, 32'hFFFF_FFFF);
        send_command(CMD_INSERT, 32'h0000_0000);
        send_command(CMD_LOOKUP, 32'hFFFF_FFFF);
        send_command(CMD_LOOKUP, 32'h0000_0000);
        send_command(CMD_LOOKUP, 32'h1234_5678);
        send_command(CMD_ERASE,  32'h5A5A_5A5A);
        send_command(CMD_ERASE,  32'h0000_0000);
        send_command(CMD_LOOKUP, 32'hFFFF_FFFF);
        send_command(CMD_ERASE,  32'hFFFF_FFFF);
        send_command(CMD_ERASE,  32'hFFFF_FFFF);
        send_command(CMD_LOOKUP, 32'h0000_0000);
        send_command(CMD_CLEAR,  32'h0000_0000);
        send_command(CMD_INSERT, 32'h8000_0000);
        send_command(CMD_INSERT, 32'h0000_0001);
        send_command(CMD_INSERT, 32'h7FFF_FFFF);
        send_command(CMD_ERASE,  32'h0000_0001);
        send_command(CMD_LOOKUP, 32'h7FFF_FFFF);
        send_command(CMD_CLEAR,  32'h8000_0000);
        send_command(CMD_LOOKUP, 32'h8000_0000);
        send_command(CMD_INSERT, 32'hA5A5_A5A5);
        send_command(CMD_CLEAR,  32'h0F0F_0F0F);

        for (int phase = 0; phase < 12; phase++) begin
            case (phase % 3)
                0:       begin ins_pct = 85; era_pct = 5;  end
                1:       begin ins_pct = 40; era_pct = 30; end
                default: begin ins_pct = 10; era_pct = 70; end
            endcase
            repeat (100) begin
                pick = $urandom_range(0, 99);
                if (pick < 2)
                    cmd = CMD_CLEAR;
                else if (pick < 2 + ins_pct)
                    cmd = CMD_INSERT;
                else if (pick < 2 + ins_pct + era_pct)
                    cmd = CMD_ERASE;
                else
                    cmd = CMD_LOOKUP;
                send_command(cmd, pick_key());
            end
        end

        i_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
